// File: hdl/sha_pkg.sv
// shared types, round constants and round functions for the sha-256 digest block
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

    typedef struct packed {
        logic [31:0] message_word;
        logic [2:0]  bytes_valid;
        logic        last_word;
    } t_msg_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_digest_word;
    } t_digest_out;

    // request after the front end has clamped the byte count
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  count;
        logic        last;
    } t_req;

    localparam int QUEUE_DEPTH = 4;
    localparam logic [2:0] MAX_BYTES = 3'd4;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS = 6'd56;

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] IV_TABLE [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage
`default_nettype wire

// File: hdl/sha_front.sv
// front end: takes message words, clamps the byte count and queues requests
`timescale 1ns / 1ps
`default_nettype none
module sha_front
    import sha_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_msg_in i_msg,
    output logic         o_full,
    output logic         o_valid,
    output t_req         o_req,
    input  wire logic    i_take
);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_req            r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;
    logic            push_ok, take_ok;
    t_req            req_in;

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_req   = r_mem[r_rp];
    assign push_ok = i_push && !o_full;
    assign take_ok = i_take && o_valid;

    always_comb begin
        req_in.word  = i_msg.message_word;
        req_in.count = (i_msg.bytes_valid > MAX_BYTES) ? MAX_BYTES : i_msg.bytes_valid;
        req_in.last  = i_msg.last_word;
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= req_in;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) r_wp <= r_wp + 1'b1;
            if (take_ok) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + CW'(push_ok) - CW'(take_ok);
        end
    end
endmodule
`default_nettype wire

// File: hdl/sha_core.sv
// back end: byte packing, padding, compression rounds and digest readout
`timescale 1ns / 1ps
`default_nettype none
module sha_core
    import sha_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_req  i_req,
    output logic       o_take,
    output logic       o_empty,
    output t_digest_out o_result,
    input  wire logic  i_pop
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BYTE  = 3'd1;
    localparam logic [2:0] S_PAD80 = 3'd2;
    localparam logic [2:0] S_PADZ  = 3'd3;
    localparam logic [2:0] S_LEN   = 3'd4;
    localparam logic [2:0] S_COMP  = 3'd5;
    localparam logic [2:0] S_ADD   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]  r_state, n_state, r_ret, n_ret, nxt;
    logic [31:0] r_hash [8], n_hash [8];
    logic [31:0] r_v [8], n_v [8];
    logic [31:0] r_win [16], n_win [16];
    logic [63:0] r_bitlen, n_bitlen, r_lensh, n_lensh;
    logic [5:0]  r_pos, n_pos, r_round, n_round;
    logic [31:0] r_word, n_word;
    logic [2:0]  r_cnt, n_cnt, r_lcnt, n_lcnt, r_oidx, n_oidx;
    logic        r_last, n_last;
    logic        do_put;
    logic [7:0]  put_b;
    logic [31:0] t1, t2, w_new, ch, maj;

    assign o_empty = (r_state != S_OUT);
    assign o_result.digest_word = r_hash[r_oidx];
    assign o_result.word_index  = r_oidx;
    assign o_result.last_digest_word = (r_oidx == 3'd7);
    assign o_take = (r_state == S_IDLE) && i_valid;

    always_comb begin
        ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1  = r_v[7] + big_sigma1(r_v[4]) + ch + K_TABLE[r_round] + r_win[0];
        t2  = big_sigma0(r_v[0]) + maj;
        w_new = r_win[0] + small_sigma0(r_win[1]) + r_win[9] + small_sigma1(r_win[14]);
    end

    always_comb begin
        n_state = r_state; n_ret = r_ret; n_hash = r_hash; n_v = r_v; n_win = r_win;
        n_bitlen = r_bitlen; n_lensh = r_lensh; n_pos = r_pos; n_round = r_round;
        n_word = r_word; n_cnt = r_cnt; n_lcnt = r_lcnt; n_oidx = r_oidx; n_last = r_last;
        do_put = 1'b0; put_b = '0; nxt = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_word = i_req.word; n_cnt = i_req.count; n_last = i_req.last;
                    n_state = S_BYTE;
                end
            end
            S_BYTE: begin
                if (r_cnt != '0) begin
                    do_put = 1'b1; put_b = r_word[31:24]; nxt = S_BYTE;
                    n_word = {r_word[23:0], 8'h00};
                    n_cnt = r_cnt - 1'b1;
                    n_bitlen = r_bitlen + 64'd8;
                end else if (r_last) begin
                    n_lensh = r_bitlen;
                    n_state = S_PAD80;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PAD80: begin
                do_put = 1'b1; put_b = PAD_BYTE; nxt = S_PADZ;
            end
            S_PADZ: begin
                if (r_pos == LEN_POS) begin
                    n_state = S_LEN; n_lcnt = '0;
                end else begin
                    do_put = 1'b1; put_b = 8'h00; nxt = S_PADZ;
                end
            end
            S_LEN: begin
                do_put = 1'b1; put_b = r_lensh[63:56];
                n_lensh = {r_lensh[55:0], 8'h00};
                n_lcnt = r_lcnt + 1'b1;
                nxt = (r_lcnt == 3'd7) ? S_OUT : S_LEN;
            end
            S_COMP: begin
                n_v[7] = r_v[6]; n_v[6] = r_v[5]; n_v[5] = r_v[4];
                n_v[4] = r_v[3] + t1;
                n_v[3] = r_v[2]; n_v[2] = r_v[1]; n_v[1] = r_v[0];
                n_v[0] = t1 + t2;
                for (int i = 0; i < 15; i++) n_win[i] = r_win[i+1];
                n_win[15] = w_new;
                n_round = r_round + 1'b1;
                if (r_round == 6'd63) n_state = S_ADD;
            end
            S_ADD: begin
                for (int i = 0; i < 8; i++) n_hash[i] = r_hash[i] + r_v[i];
                n_oidx = '0;
                n_state = r_ret;
            end
            S_OUT: begin
                if (i_pop) begin
                    n_oidx = r_oidx + 1'b1;
                    if (r_oidx == 3'd7) begin
                        n_hash = IV_TABLE; n_bitlen = '0; n_pos = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (do_put) begin
            n_win[r_pos[5:2]][{~r_pos[1:0], 3'b000} +: 8] = put_b;
            n_pos = r_pos + 1'b1;
            if (r_pos == 6'd63) begin
                n_ret = nxt; n_state = S_COMP; n_v = r_hash; n_round = '0;
            end else begin
                n_state = nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v; r_win <= n_win; r_lensh <= n_lensh; r_word <= n_word;
        r_cnt <= n_cnt; r_lcnt <= n_lcnt; r_last <= n_last; r_round <= n_round;
        r_ret <= n_ret;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_hash   <= IV_TABLE;
            r_bitlen <= '0;
            r_pos    <= '0;
            r_oidx   <= '0;
        end else begin
            r_state  <= n_state;
            r_hash   <= n_hash;
            r_bitlen <= n_bitlen;
            r_pos    <= n_pos;
            r_oidx   <= n_oidx;
        end
    end
endmodule
`default_nettype wire

// File: hdl/sha256_message_digest_top.sv
// top level of the streaming sha-256 digest block
// processing: the core picks up a request in idle, packs each valid byte, then closes
//   the word before it takes another; each full 64-byte block also runs a compression
//   (64 rounds, one round a cycle, plus hash add)
// finish: a last word needs padding bytes (one a cycle), a final compression,
//   then the eight digest words are offered one per pop
// reset: synchronous active low; hash returns to the initial values, length
//   and byte position clear, request queue empties
`timescale 1ns / 1ps
`default_nettype none
module sha256_message_digest_top
    import sha_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_msg_in i_msg,
    output logic         o_full,
    output logic         o_empty,
    output t_digest_out  o_result,
    input  wire logic    i_pop
);
    // requests cross from the front queue to the core
    logic q_valid, q_take;
    t_req q_req;

    // front: accept and clamp byte counts, buffer a few requests
    sha_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_msg   (i_msg),
        .o_full  (o_full),
        .o_valid (q_valid),
        .o_req   (q_req),
        .i_take  (q_take)
    );

    // back: byte packing, padding, rounds, digest readout
    sha_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_req    (q_req),
        .o_take   (q_take),
        .o_empty  (o_empty),
        .o_result (o_result),
        .i_pop    (i_pop)
    );
endmodule
`default_nettype wire
